>>> design/rcmu_pkg.sv
`timescale 1ns / 1ps

package rcmu_pkg;

  // request kinds
  localparam logic REQ_LOCK   = 1'b0;
  localparam logic REQ_UNLOCK = 1'b1;

  // result status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_ISR       = 2'd1;
  localparam logic [1:0] STATUS_NOT_OWNER = 2'd2;
  localparam logic [1:0] STATUS_Q_FULL    = 2'd3;

  // configuration register indexes
  localparam logic REG_CEILING = 1'b0;

  localparam logic [7:0] DEPTH_MAX = 8'hFF;

  typedef struct packed {
    logic       req_type;
    logic [7:0] caller_id;
    logic [7:0] caller_priority;
    logic       in_isr;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic       caller_blocked;
    logic [7:0] caller_new_priority;
    logic       priority_changed;
    logic       woken_valid;
    logic [7:0] woken_id;
    logic       owner_valid;
    logic [7:0] owner_id;
    logic [7:0] depth;
  } rsp_t;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_req_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

endpackage

>>> design/rcmu_wait_fifo.sv
`timescale 1ns / 1ps

module rcmu_wait_fifo #(
  parameter int WAIT_DEPTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  rcmu_pkg::fifo_req_t    req_i,
  input  logic [7:0]             push_id_i,
  output logic [7:0]             head_id_o,
  output rcmu_pkg::fifo_stat_t   stat_o
);
  import rcmu_pkg::*;

  localparam int PTR_W = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int CNT_W = $clog2(WAIT_DEPTH + 1);

  logic [7:0]       mem [WAIT_DEPTH];
  logic [PTR_W-1:0] head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [7:0]       rd_q;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
    next_ptr = (ptr == PTR_W'(WAIT_DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
  endfunction

  always_comb begin
    head_d  = req_i.pop  ? next_ptr(head_q) : head_q;
    tail_d  = req_i.push ? next_ptr(tail_q) : tail_q;
    count_d = count_q;
    if (req_i.push) begin
      count_d = count_q + CNT_W'(1);
    end else if (req_i.pop) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.push) begin
      mem[tail_q] <= push_id_i;
    end
  end

  // prefetch the entry at the next head; bypass a push into the slot at the next head
  always_ff @(posedge clk_i) begin
    if (req_i.push && (tail_q == head_d)) begin
      rd_q <= push_id_i;
    end else begin
      rd_q <= mem[head_d];
    end
  end

  assign head_id_o    = rd_q;
  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == CNT_W'(WAIT_DEPTH));

endmodule

>>> design/recursive_ceiling_mutex_unit.sv
`timescale 1ns / 1ps
// throughput: one request per cycle unless out_ready_i stalls the output;
//   the mutex state loop closes through the single evaluate stage between
//   the input register and the result register
// reset: mutex free, depth 0, wait queue empty, ceiling 0, both stages empty;
//   wait queue entries are not cleared

module recursive_ceiling_mutex_unit #(
  parameter int WAIT_DEPTH = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  rcmu_pkg::req_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output rcmu_pkg::rsp_t  out_data_o,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);
  import rcmu_pkg::*;

  logic       s1_valid_q;
  req_t       s1_q;
  logic       out_valid_q;
  rsp_t       out_q, rsp;
  logic       advance, fire;

  logic [7:0] ceiling_q;

  logic       held_q, held_d;
  logic [7:0] holder_q, holder_d;
  logic [7:0] rec_q, rec_d;
  logic [7:0] saved_q, saved_d;
  logic       raised_q, raised_d;

  fifo_req_t  fifo_req;
  fifo_stat_t fifo_stat;
  logic [7:0] head_id;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CEILING) ? {24'd0, ceiling_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ceiling_q <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_CEILING)) begin
      ceiling_q <= pwdata[7:0];
    end
  end

  // pipeline control
  assign advance    = !out_valid_q || out_ready_i;
  assign fire       = s1_valid_q && advance;
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_q <= in_data_i;
    end
    if (fire) begin
      out_q <= rsp;
    end
  end

  // evaluate one request against the mutex state
  always_comb begin
    held_d       = held_q;
    holder_d     = holder_q;
    rec_d        = rec_q;
    saved_d      = saved_q;
    raised_d     = raised_q;
    fifo_req     = '0;

    rsp                     = '0;
    rsp.status              = STATUS_OK;
    rsp.caller_new_priority = s1_q.caller_priority;

    if (s1_q.in_isr) begin
      rsp.status = STATUS_ISR;
    end else if (s1_q.req_type == REQ_LOCK) begin
      if (!held_q) begin
        held_d   = 1'b1;
        holder_d = s1_q.caller_id;
        rec_d    = '0;
        if ((ceiling_q != '0) && (s1_q.caller_priority < ceiling_q)) begin
          saved_d                 = s1_q.caller_priority;
          raised_d                = 1'b1;
          rsp.caller_new_priority = ceiling_q;
          rsp.priority_changed    = 1'b1;
        end else begin
          raised_d = 1'b0;
        end
      end else if (holder_q == s1_q.caller_id) begin
        if (rec_q != DEPTH_MAX) begin
          rec_d = rec_q + 8'd1;
        end
      end else if (fifo_stat.full) begin
        rsp.status = STATUS_Q_FULL;
      end else begin
        fifo_req.push      = fire;
        rsp.caller_blocked = 1'b1;
      end
    end else begin
      if (!held_q || (holder_q != s1_q.caller_id)) begin
        rsp.status = STATUS_NOT_OWNER;
      end else if (rec_q != '0) begin
        rec_d = rec_q - 8'd1;
      end else begin
        if (raised_q) begin
          rsp.caller_new_priority = saved_q;
          rsp.priority_changed    = 1'b1;
          raised_d                = 1'b0;
        end
        if (!fifo_stat.empty) begin
          // ownership passes to the oldest waiter
          fifo_req.pop    = fire;
          holder_d        = head_id;
          rec_d           = '0;
          rsp.woken_valid = 1'b1;
          rsp.woken_id    = head_id;
        end else begin
          held_d = 1'b0;
        end
      end
    end

    rsp.owner_valid = held_d;
    rsp.owner_id    = held_d ? holder_d : 8'd0;
    rsp.depth       = rec_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q   <= 1'b0;
      holder_q <= '0;
      rec_q    <= '0;
      saved_q  <= '0;
      raised_q <= 1'b0;
    end else if (fire) begin
      held_q   <= held_d;
      holder_q <= holder_d;
      rec_q    <= rec_d;
      saved_q  <= saved_d;
      raised_q <= raised_d;
    end
  end

  rcmu_wait_fifo #(
    .WAIT_DEPTH(WAIT_DEPTH)
  ) u_wait_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (fifo_req),
    .push_id_i (s1_q.caller_id),
    .head_id_o (head_id),
    .stat_o    (fifo_stat)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a free mutex never has waiters
  a_free_no_waiters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !held_q |-> fifo_stat.empty)
    else $error("waiters queued on a free mutex");

  // a queued caller is never reported together with a handoff
  a_block_xor_wake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.caller_blocked && out_q.woken_valid))
    else $error("blocked and woken in one result");

  // the queue is pushed or popped, not both, only on a processed transfer
  a_fifo_on_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fifo_req.push || fifo_req.pop) |-> (fire && held_q && !(fifo_req.push && fifo_req.pop)))
    else $error("wait queue touched outside a processed request");

  // a processed lock by the owner keeps ownership on the next cycle
  a_owner_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !s1_q.in_isr && (s1_q.req_type == REQ_LOCK) && held_q
      && (holder_q == s1_q.caller_id)) |=> (held_q && (holder_q == $past(holder_q))))
    else $error("recursive lock lost ownership");

endmodule
